// ===== src/vkle_pkg.sv =====
package vkle_pkg;

	// default build parameters
	localparam int MAX_KEY_DEF     = 64;
	localparam int BLOCK_BYTES_DEF = 256;
	localparam int TOTAL_WIDTH_DEF = 24;

	// fixed field widths of the words on the ports
	localparam int BYTE_W = 8;
	localparam int KEY_W  = 6;
	localparam int CNT_W  = 24;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              block_end;
		logic              text_end;
	} in_word_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_length;
		logic [CNT_W-1:0] best_count;
	} out_word_t;

endpackage

// ===== src/vkle_stream_if.sv =====
interface vkle_stream_if #(
	parameter type word_t = logic
) ();

	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== src/vkle_core.sv =====
module vkle_core #(
	parameter int MAX_KEY     = vkle_pkg::MAX_KEY_DEF,
	parameter int BLOCK_BYTES = vkle_pkg::BLOCK_BYTES_DEF,
	parameter int TOTAL_WIDTH = vkle_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	vkle_stream_if.sink                           bytes,
	input  logic                                  take,
	output logic                                  fire,
	output logic [MAX_KEY-1:0][TOTAL_WIDTH-1:0]   leaves
);

	localparam int BYTE_W = vkle_pkg::BYTE_W;
	localparam int FILL_W = $clog2(BLOCK_BYTES);
	localparam int IDX_W  = $clog2(MAX_KEY);
	localparam int CMP_W  = (FILL_W > IDX_W) ? FILL_W : IDX_W;

	logic                                   v_s1;
	logic [BYTE_W-1:0]                      byte_s1;
	logic                                   blk_s1;
	logic                                   txt_s1;

	logic [MAX_KEY-1:1][BYTE_W-1:0]         hist_q;
	logic [FILL_W-1:0]                      fill_q;
	logic [MAX_KEY-1:1][TOTAL_WIDTH-1:0]    tot_q;

	logic                                   consume;
	logic [MAX_KEY-1:1]                     match;
	logic [MAX_KEY-1:1][TOTAL_WIDTH-1:0]    tot_nx;
	logic [FILL_W-1:0]                      fill_inc;
	logic                                   fill_end;

	// a text_end word may only leave when the search tree has room
	assign consume     = v_s1 && (!txt_s1 || take);
	assign fire        = consume && txt_s1;
	assign bytes.ready = !v_s1 || consume;

	always_comb begin
		leaves[0] = '0;
		for (int j = 1; j < MAX_KEY; j++) begin
			// only bytes of the current block take part
			match[j]  = (CMP_W'(j) <= CMP_W'(fill_q)) && (hist_q[j] == byte_s1);
			tot_nx[j] = tot_q[j] + TOTAL_WIDTH'(match[j] && (tot_q[j] != '1));
			leaves[j] = tot_nx[j];
		end
	end

	assign fill_inc = fill_q + FILL_W'(1);
	assign fill_end = blk_s1 || txt_s1 || (fill_inc >= FILL_W'(BLOCK_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fill_q <= '0;
			tot_q  <= '0;
		end else begin
			if (bytes.ready) begin
				v_s1 <= bytes.valid;
			end
			if (consume) begin
				fill_q <= fill_end ? '0 : fill_inc;
				tot_q  <= txt_s1 ? '0 : tot_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data.text_byte;
			blk_s1  <= bytes.data.block_end;
			txt_s1  <= bytes.data.text_end;
		end
		if (consume) begin
			hist_q[1] <= byte_s1;
			for (int j = 2; j < MAX_KEY; j++) begin
				hist_q[j] <= hist_q[j-1];
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (tot_q == '0))
		else $error("totals not cleared after text end");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FILL_W'(BLOCK_BYTES - 1))
		else $error("block fill beyond block length");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && blk_s1) |=> (fill_q == '0))
		else $error("block did not restart after block end");
`endif

endmodule

// ===== src/vkle_argmax.sv =====
module vkle_argmax #(
	parameter int MAX_KEY     = vkle_pkg::MAX_KEY_DEF,
	parameter int TOTAL_WIDTH = vkle_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [MAX_KEY-1:0][TOTAL_WIDTH-1:0]   leaves,
	input  logic                                  fire,
	output logic                                  take,
	vkle_stream_if.source                         result
);

	localparam int LEVELS = $clog2(MAX_KEY);
	localparam int LEAVES = 1 << LEVELS;
	localparam int IDX_W  = LEVELS;
	localparam int KEY_W  = vkle_pkg::KEY_W;
	localparam int CNT_W  = vkle_pkg::CNT_W;

	logic [LEVELS-1:0]      v_q;
	logic [LEVELS-1:0]      take_d;
	logic [LEVELS-1:0]      v_in;
	logic [TOTAL_WIDTH-1:0] leaf_val [LEAVES];
	// heap order: node 1 is the root, children of n are 2n and 2n+1
	logic [TOTAL_WIDTH-1:0] val_q [1:LEAVES-1];
	logic [IDX_W-1:0]       idx_q [1:LEAVES-1];

	// depth 0 is the root and the output register
	always_comb begin
		take_d[0] = !v_q[0] || result.ready;
		for (int d = 1; d < LEVELS; d++) begin
			take_d[d] = !v_q[d] || take_d[d-1];
		end
		v_in[LEVELS-1] = fire;
		for (int d = 0; d < LEVELS - 1; d++) begin
			v_in[d] = v_q[d+1];
		end
	end

	assign take = take_d[LEVELS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int d = 0; d < LEVELS; d++) begin
				if (take_d[d]) begin
					v_q[d] <= v_in[d];
				end
			end
		end
	end

	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < MAX_KEY) begin : g_real
			assign leaf_val[i] = leaves[i];
		end else begin : g_pad
			assign leaf_val[i] = '0;
		end
	end

	for (genvar n = 1; n < LEAVES; n++) begin : g_node
		localparam int D = $clog2(n + 1) - 1;
		logic [TOTAL_WIDTH-1:0] a_val;
		logic [TOTAL_WIDTH-1:0] b_val;
		logic [IDX_W-1:0]       a_idx;
		logic [IDX_W-1:0]       b_idx;

		if (2 * n >= LEAVES) begin : g_bottom
			assign a_val = leaf_val[2*n - LEAVES];
			assign b_val = leaf_val[2*n + 1 - LEAVES];
			assign a_idx = IDX_W'(2*n - LEAVES);
			assign b_idx = IDX_W'(2*n + 1 - LEAVES);
		end else begin : g_inner
			assign a_val = val_q[2*n];
			assign b_val = val_q[2*n + 1];
			assign a_idx = idx_q[2*n];
			assign b_idx = idx_q[2*n + 1];
		end

		// lower shift wins ties
		always_ff @(posedge clk) begin
			if (take_d[D]) begin
				if (b_val > a_val) begin
					val_q[n] <= b_val;
					idx_q[n] <= b_idx;
				end else begin
					val_q[n] <= a_val;
					idx_q[n] <= a_idx;
				end
			end
		end
	end

	assign result.valid           = v_q[0];
	assign result.data.key_length = KEY_W'(idx_q[1]);
	assign result.data.best_count = CNT_W'(val_q[1]);

`ifndef SYNTHESIS
	a_zero_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[0] && (idx_q[1] == '0)) |-> (val_q[1] == '0))
		else $error("shift zero chosen with a non-zero total");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] |-> (idx_q[1] <= IDX_W'(MAX_KEY - 1)))
		else $error("padding leaf chosen");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[0] && !result.ready) |=> (v_q[0] && $stable(idx_q[1]) && $stable(val_q[1])))
		else $error("waiting result changed");
`endif

endmodule

// ===== src/vigenere_key_length_estimator.sv =====
// Result path: a text_end word passes the input register, then six registered argmax
//   levels at the default MAX_KEY of 64; the result is held on the output until taken.
// Throughput: one word per cycle, but a text_end word waits in the input register while
//   the bottom tree level is full; the tree holds one result per level, so words keep
//   flowing while a result waits on the output.
// Reset (arst_n, async, active low): all coincidence totals, block fill and valids clear.
module vigenere_key_length_estimator #(
	parameter int MAX_KEY     = vkle_pkg::MAX_KEY_DEF,
	parameter int BLOCK_BYTES = vkle_pkg::BLOCK_BYTES_DEF,
	parameter int TOTAL_WIDTH = vkle_pkg::TOTAL_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	vkle_stream_if.sink   bytes,
	vkle_stream_if.source result
);

	// Structure:
	//   vkle_core   - input register, byte history (a shift line of MAX_KEY-1 taps),
	//                 block fill counter and one saturating total per shift. All
	//                 comparisons and increments happen in the same cycle that a word
	//                 leaves the input register.
	//   vkle_argmax - registered compare tree over the freshly updated totals.
	//                 It gets a valid entry only for a word carrying text_end; the totals
	//                 are cleared in the same cycle, so the next text starts clean.
	// Backpressure: each tree level moves when it is empty or the level after it
	// moves; a text_end word is held in the input register until the bottom level
	// can take it. Ordinary words never wait on the tree.

	logic                                fire;
	logic                                take;
	logic [MAX_KEY-1:0][TOTAL_WIDTH-1:0] leaves;

	vkle_core #(
		.MAX_KEY     (MAX_KEY),
		.BLOCK_BYTES (BLOCK_BYTES),
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.take   (take),
		.fire   (fire),
		.leaves (leaves)
	);

	// smallest shift with the largest total; shift 0 (total zero) when none matched
	vkle_argmax #(
		.MAX_KEY     (MAX_KEY),
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_argmax (
		.clk    (clk),
		.arst_n (arst_n),
		.leaves (leaves),
		.fire   (fire),
		.take   (take),
		.result (result)
	);

endmodule

// ===== test/vigenere_key_length_estimator_tb.sv =====
module vigenere_key_length_estimator_tb;

	// shifts compared per byte, and the fill at which a block closes on its own
	localparam int SHIFT_N     = vkle_pkg::MAX_KEY_DEF - 1;
	localparam int BLOCK_LIMIT = vkle_pkg::BLOCK_BYTES_DEF - 1;
	localparam logic [vkle_pkg::CNT_W-1:0] TOTAL_SAT = '1;

	// length of the quiet spell after the drain, to catch any stray result
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_WORDS  = 190;

	logic clk;
	logic arst_n;

	vkle_stream_if #(.word_t(vkle_pkg::in_word_t))  bytes_if ();
	vkle_stream_if #(.word_t(vkle_pkg::out_word_t)) result_if ();

	vigenere_key_length_estimator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if),
		.result (result_if)
	);

	// ---------------------------------------------------------------------
	// Directed stimulus. Each row sends reps words; the byte starts at first
	// and moves on by stride per word. Where typed is set the estimate is
	// written in by hand, otherwise the coincidence model supplies it.
	// ---------------------------------------------------------------------
	typedef struct packed {
		logic [7:0]                 first;
		logic [7:0]                 stride;
		logic                       blk;
		logic                       txt;
		logic [9:0]                 reps;
		logic                       typed;
		logic [vkle_pkg::KEY_W-1:0] key;
		logic [vkle_pkg::CNT_W-1:0] cnt;
	} stim_row_t;

	localparam int ROW_N = 21;

	stim_row_t stim_rows [0:ROW_N-1] = '{
		// lone byte straight after reset: nothing to compare against
		'{8'hFF, 8'h00, 1'b0, 1'b1, 10'd1,   1'b1, 6'd0,  24'd0},
		// one coincidence at shift one
		'{8'h41, 8'h00, 1'b0, 1'b0, 10'd1,   1'b0, 6'd0,  24'd0},
		'{8'h41, 8'h00, 1'b0, 1'b1, 10'd1,   1'b1, 6'd1,  24'd1},
		// same byte either side of a block end must not match
		'{8'h42, 8'h00, 1'b1, 1'b0, 10'd1,   1'b0, 6'd0,  24'd0},
		'{8'h42, 8'h00, 1'b0, 1'b1, 10'd1,   1'b1, 6'd0,  24'd0},
		// 255-byte block of zeros, closed by text_end on its last byte
		'{8'h00, 8'h00, 1'b0, 1'b0, 10'd254, 1'b0, 6'd0,  24'd0},
		'{8'h00, 8'h00, 1'b0, 1'b1, 10'd1,   1'b1, 6'd1,  24'd254},
		// block closes by itself after 255 bytes: the next byte starts afresh
		'{8'h00, 8'h00, 1'b0, 1'b0, 10'd255, 1'b0, 6'd0,  24'd0},
		'{8'h00, 8'h00, 1'b0, 1'b1, 10'd1,   1'b1, 6'd1,  24'd254},
		// widest shift: one match 63 bytes apart
		'{8'h7E, 8'h00, 1'b0, 1'b0, 10'd1,   1'b0, 6'd0,  24'd0},
		'{8'h01, 8'h01, 1'b0, 1'b0, 10'd62,  1'b0, 6'd0,  24'd0},
		'{8'h7E, 8'h00, 1'b0, 1'b1, 10'd1,   1'b1, 6'd63, 24'd1},
		// tie between shifts one and two goes to the smaller
		'{8'h10, 8'h00, 1'b0, 1'b0, 10'd2,   1'b0, 6'd0,  24'd0},
		'{8'h20, 8'h00, 1'b0, 1'b0, 10'd1,   1'b0, 6'd0,  24'd0},
		'{8'h99, 8'h00, 1'b0, 1'b0, 10'd1,   1'b0, 6'd0,  24'd0},
		'{8'h20, 8'h00, 1'b0, 1'b1, 10'd1,   1'b1, 6'd1,  24'd1},
		// both flags at once; text_end closes the block as well
		'{8'h33, 8'h00, 1'b1, 1'b1, 10'd1,   1'b1, 6'd0,  24'd0},
		'{8'h33, 8'h00, 1'b1, 1'b1, 10'd1,   1'b1, 6'd0,  24'd0},
		// period-four text, then back-to-back text ends
		'{8'hC3, 8'h40, 1'b0, 1'b0, 10'd70,  1'b0, 6'd0,  24'd0},
		'{8'h5A, 8'h00, 1'b1, 1'b0, 10'd1,   1'b0, 6'd0,  24'd0},
		'{8'hFF, 8'h00, 1'b0, 1'b1, 10'd3,   1'b0, 6'd0,  24'd0}
	};

	// ---------------------------------------------------------------------
	// Coincidence model state
	// ---------------------------------------------------------------------
	logic [7:0]                 hist_bytes [1:SHIFT_N];   // [1] is the newest byte
	int                         blk_fill;
	logic [vkle_pkg::CNT_W-1:0] shift_cnt  [1:SHIFT_N];

	vkle_pkg::out_word_t est_q [$];           // estimates awaiting the output

	int src_idle_pct;
	int sink_stall_pct;
	int err_cnt;
	int words_sent;
	int est_checked;
	int cycle_cnt;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Take one byte into the model; returns the estimate when text_end fires.
	task automatic count_coincidences(input vkle_pkg::in_word_t w, output logic fires,
			output vkle_pkg::out_word_t est);
		logic [vkle_pkg::CNT_W-1:0] top;
		logic [vkle_pkg::KEY_W-1:0] pick;
		for (int j = 1; j <= SHIFT_N; j++) begin
			if (j <= blk_fill && hist_bytes[j] == w.text_byte && shift_cnt[j] != TOTAL_SAT)
				shift_cnt[j]++;
		end
		for (int j = SHIFT_N; j > 1; j--)
			hist_bytes[j] = hist_bytes[j-1];
		hist_bytes[1] = w.text_byte;

		blk_fill++;
		if (w.block_end || w.text_end || blk_fill >= BLOCK_LIMIT)
			blk_fill = 0;

		fires = w.text_end;
		est   = '0;
		if (fires) begin
			top  = '0;
			pick = '0;
			// strict compare keeps the smallest shift on a tie
			for (int j = 1; j <= SHIFT_N; j++) begin
				if (shift_cnt[j] > top) begin
					top  = shift_cnt[j];
					pick = vkle_pkg::KEY_W'(j);
				end
			end
			est.key_length = pick;
			est.best_count = top;
			for (int j = 1; j <= SHIFT_N; j++)
				shift_cnt[j] = '0;
		end
	endtask

	// Present one word from a falling edge, hold it until taken, then log the
	// estimate it causes. A typed estimate replaces the modelled one.
	task automatic send_word(input vkle_pkg::in_word_t w, input logic typed,
			input vkle_pkg::out_word_t typed_est);
		logic                fires;
		vkle_pkg::out_word_t est;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			bytes_if.valid <= 1'b0;
			@(negedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data  <= w;
		do
			@(posedge clk);
		while (!bytes_if.ready);
		words_sent++;
		count_coincidences(w, fires, est);
		if (fires)
			est_q.push_back(typed ? typed_est : est);
		@(negedge clk);
	endtask

	function automatic int pick_block_len();
		// mostly ordinary lines, now and then one that may run long enough to close on its own
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(200, 300);
		return $urandom_range(1, 120);
	endfunction

	// One random text of n words. Most texts look like Vigenere output: a
	// random key of random period added to a skewed plaintext; the rest are
	// a small alphabet or raw noise.
	task automatic send_text(input int n);
		int                 mode;
		int                 period;
		int                 blk_left;
		logic [7:0]         key [0:SHIFT_N-1];
		vkle_pkg::in_word_t w;
		mode     = $urandom_range(0, 9);
		period   = $urandom_range(1, SHIFT_N);
		blk_left = pick_block_len();
		foreach (key[k])
			key[k] = 8'($urandom_range(0, 255));
		for (int i = 0; i < n; i++) begin
			if (mode <= 5)
				w.text_byte = key[i % period] + 8'($urandom_range(0, 5));
			else if (mode <= 7)
				w.text_byte = 8'h61 + 8'($urandom_range(0, 3));
			else
				w.text_byte = 8'($urandom_range(0, 255));
			blk_left--;
			// a stray block end now and then breaks the period
			w.block_end = (blk_left == 0) || ($urandom_range(0, 49) == 0);
			if (w.block_end)
				blk_left = pick_block_len();
			w.text_end = (i == n - 1);
			send_word(w, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------------
	// Clock, reset and start-up values
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n          = 1'b0;
		bytes_if.valid  = 1'b0;
		bytes_if.data   = '0;
		result_if.ready = 1'b0;
	end

	// Result side: ready changes only on the falling edge.
	always @(negedge clk)
		result_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

	// Result checker: every word taken is matched against the oldest estimate.
	always @(posedge clk) begin
		vkle_pkg::out_word_t exp_w;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (est_q.size() == 0) begin
				report_mismatch($sformatf("result with none expected: key %0d count %0d",
					result_if.data.key_length, result_if.data.best_count));
			end else begin
				exp_w = est_q.pop_front();
				est_checked++;
				if (result_if.data.key_length !== exp_w.key_length)
					report_mismatch($sformatf("key_length %0d, expected %0d",
						result_if.data.key_length, exp_w.key_length));
				if (result_if.data.best_count !== exp_w.best_count)
					report_mismatch($sformatf("best_count %0d, expected %0d",
						result_if.data.best_count, exp_w.best_count));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d estimates outstanding",
				cycle_cnt, est_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		vkle_pkg::in_word_t  w;
		vkle_pkg::out_word_t typed_est;
		int                  phase_start;

		err_cnt        = 0;
		words_sent     = 0;
		est_checked    = 0;
		cycle_cnt      = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		blk_fill       = 0;
		for (int j = 1; j <= SHIFT_N; j++) begin
			hist_bytes[j] = '0;
			shift_cnt[j]  = '0;
		end

		// hold reset, then release it on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows, no idling
		for (int r = 0; r < ROW_N; r++) begin
			typed_est.key_length = stim_rows[r].key;
			typed_est.best_count = stim_rows[r].cnt;
			for (int k = 0; k < int'(stim_rows[r].reps); k++) begin
				w.text_byte = stim_rows[r].first + 8'(k) * stim_rows[r].stride;
				w.block_end = stim_rows[r].blk;
				w.text_end  = stim_rows[r].txt;
				send_word(w, stim_rows[r].typed, typed_est);
			end
		end

		// random texts over four traffic phases: free flow, sparse sender,
		// stalling receiver, light noise on both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
				default: begin src_idle_pct = 8; sink_stall_pct = 8; end
			endcase
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				if ($urandom_range(0, 9) == 0)
					send_text($urandom_range(200, 350));
				else
					send_text($urandom_range(1, 50));
			end
		end
		bytes_if.valid <= 1'b0;

		// drain, then a quiet spell to catch any stray output
		while (est_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d byte words sent, %0d key length estimates checked",
			words_sent, est_checked);
		$display("  directed edge cases plus random ciphertext under four idle/stall mixes");
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
